// ===== rtl/core/slpc_pkg.sv =====
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types, codes and the state table of the status LED pattern controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

    localparam int unsigned NOW_W  = 32;
    localparam int unsigned CODE_W = 4;
    localparam int unsigned RGB_W  = 3;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned PRIO_W = 3;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_POLL  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        PAT_OFF   = 2'd0,
        PAT_SOLID = 2'd1,
        PAT_SLOW  = 2'd2,
        PAT_FAST  = 2'd3
    } pattern_t;

    typedef enum logic [0:0] {
        CFG_OVERLAY_DURATION = 1'b0,
        CFG_BOOT_FLASH       = 1'b1
    } cfg_index_t;

    localparam logic [CODE_W-1:0] ST_UNKNOWN      = 4'd0;
    localparam logic [CODE_W-1:0] ST_BOOT         = 4'd1;
    localparam logic [CODE_W-1:0] ST_WAITGPS      = 4'd2;
    localparam logic [CODE_W-1:0] ST_ACQUIRING    = 4'd3;
    localparam logic [CODE_W-1:0] ST_LOCKED       = 4'd4;
    localparam logic [CODE_W-1:0] ST_HEARTBEAT    = 4'd5;
    localparam logic [CODE_W-1:0] ST_HOLDOVER     = 4'd6;
    localparam logic [CODE_W-1:0] ST_NOOSCILLATOR = 4'd7;
    localparam logic [CODE_W-1:0] ST_FATAL        = 4'd8;
    localparam logic [CODE_W-1:0] ST_USBDEBUG     = 4'd9;
    localparam logic [CODE_W-1:0] ST_HOSTACTIVITY = 4'd10;

    // red = bit 2, green = bit 1, blue = bit 0
    localparam logic [RGB_W-1:0] RGB_OFF     = 3'b000;
    localparam logic [RGB_W-1:0] RGB_BLUE    = 3'b001;
    localparam logic [RGB_W-1:0] RGB_GREEN   = 3'b010;
    localparam logic [RGB_W-1:0] RGB_CYAN    = 3'b011;
    localparam logic [RGB_W-1:0] RGB_RED     = 3'b100;
    localparam logic [RGB_W-1:0] RGB_MAGENTA = 3'b101;
    localparam logic [RGB_W-1:0] RGB_YELLOW  = 3'b110;
    localparam logic [RGB_W-1:0] RGB_WHITE   = 3'b111;

    typedef struct packed {
        kind_t             kind;
        logic [CODE_W-1:0] state_code;
        logic [NOW_W-1:0]  now_ms;
        logic              slow_on;
        logic              fast_on;
    } item_t;

    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        pattern_t         pattern;
    } look_t;

    function automatic logic [PRIO_W-1:0] priority_of(input logic [CODE_W-1:0] s);
        logic [PRIO_W-1:0] p;
        case (s)
            ST_FATAL:                  p = 3'd6;
            ST_NOOSCILLATOR:           p = 3'd5;
            ST_WAITGPS:                p = 3'd4;
            ST_HOLDOVER:               p = 3'd3;
            ST_ACQUIRING, ST_USBDEBUG: p = 3'd2;
            ST_LOCKED:                 p = 3'd1;
            default:                   p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic look_t base_look(input logic [CODE_W-1:0] s);
        look_t l;
        case (s)
            ST_BOOT:         l = '{rgb: RGB_WHITE,   pattern: PAT_SOLID};
            ST_WAITGPS:      l = '{rgb: RGB_BLUE,    pattern: PAT_SLOW};
            ST_ACQUIRING:    l = '{rgb: RGB_BLUE,    pattern: PAT_SOLID};
            ST_LOCKED:       l = '{rgb: RGB_GREEN,   pattern: PAT_SOLID};
            ST_HOLDOVER:     l = '{rgb: RGB_YELLOW,  pattern: PAT_SLOW};
            ST_NOOSCILLATOR: l = '{rgb: RGB_RED,     pattern: PAT_FAST};
            ST_FATAL:        l = '{rgb: RGB_RED,     pattern: PAT_SOLID};
            ST_USBDEBUG:     l = '{rgb: RGB_MAGENTA, pattern: PAT_SOLID};
            default:         l = '{rgb: RGB_OFF,     pattern: PAT_OFF};
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slpc_phase.sv =====
// ----------------------------------------------------------------------------
// slpc_phase
// Blink phase bits of a timestamp: floor(now/125) and floor(now/500) parity.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_phase (
    input  wire logic [slpc_pkg::NOW_W-1:0] now_ms,
    output logic                            slow_on,
    output logic                            fast_on
);
    import slpc_pkg::*;

    // floor(n/125) = (n * ceil(2^35/125)) >> 35, exact for 32-bit n
    localparam int unsigned     RECIP_W = 29;
    localparam int unsigned     SHIFT   = 35;
    localparam int unsigned     PROD_W  = NOW_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;

    logic [PROD_W-1:0] prod;

    assign prod    = PROD_W'(now_ms) * PROD_W'(RECIP);
    assign fast_on = ~prod[SHIFT];
    assign slow_on = ~prod[SHIFT+2];

endmodule

`default_nettype wire

// ===== rtl/core/slpc_core.sv =====
// ----------------------------------------------------------------------------
// slpc_core
// Base state, overlay and boot flash registers with event and poll update.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [slpc_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            fire,
    input  wire slpc_pkg::item_t                 item,
    output logic [slpc_pkg::RGB_W-1:0]           rgb
);
    import slpc_pkg::*;

    logic [CFG_W-1:0]  ovl_dur_reg;
    logic [CFG_W-1:0]  boot_ms_reg;
    logic [CODE_W-1:0] base_state_reg, base_state_next;
    logic [RGB_W-1:0]  base_rgb_reg, base_rgb_next;
    pattern_t          pattern_reg, pattern_next;
    logic [RGB_W-1:0]  ovl_rgb_reg, ovl_rgb_next;
    logic [NOW_W-1:0]  ovl_dl_reg, ovl_dl_next;
    logic [NOW_W-1:0]  boot_dl_reg, boot_dl_next;

    look_t            look;
    logic [NOW_W-1:0] boot_diff;
    logic [NOW_W-1:0] ovl_diff;
    logic             boot_expire;
    logic             ovl_show;
    logic             blink_on;

    assign look      = base_look(item.state_code);
    assign boot_diff = item.now_ms - boot_dl_reg;

    always_comb begin
        base_state_next = base_state_reg;
        base_rgb_next   = base_rgb_reg;
        pattern_next    = pattern_reg;
        ovl_rgb_next    = ovl_rgb_reg;
        ovl_dl_next     = ovl_dl_reg;
        boot_dl_next    = boot_dl_reg;
        boot_expire     = 1'b0;
        ovl_show        = 1'b0;
        blink_on        = 1'b0;
        ovl_diff        = '0;
        rgb             = RGB_OFF;
        if (item.kind == KIND_EVENT) begin
            if (item.state_code == ST_HEARTBEAT || item.state_code == ST_HOSTACTIVITY) begin
                if (priority_of(base_state_reg) <= 3'd1) begin
                    ovl_rgb_next = (item.state_code == ST_HEARTBEAT) ? RGB_GREEN : RGB_CYAN;
                    ovl_dl_next  = item.now_ms + NOW_W'(ovl_dur_reg);
                end
            end else begin
                base_state_next = (look.pattern == PAT_OFF) ? ST_UNKNOWN : item.state_code;
                base_rgb_next   = look.rgb;
                pattern_next    = look.pattern;
                ovl_dl_next     = '0;
                if (item.state_code == ST_BOOT) begin
                    boot_dl_next = item.now_ms + NOW_W'(boot_ms_reg);
                end
            end
        end else begin
            boot_expire = (boot_dl_reg != '0) && !boot_diff[NOW_W-1];
            if (boot_expire) begin
                boot_dl_next = '0;
                if (base_state_reg == ST_BOOT) begin
                    base_state_next = ST_UNKNOWN;
                    base_rgb_next   = RGB_OFF;
                    pattern_next    = PAT_OFF;
                    ovl_dl_next     = '0;
                end
            end
            ovl_diff = item.now_ms - ovl_dl_next;
            ovl_show = (ovl_dl_next != '0) && ovl_diff[NOW_W-1];
            case (pattern_next)
                PAT_SOLID: blink_on = 1'b1;
                PAT_SLOW:  blink_on = item.slow_on;
                PAT_FAST:  blink_on = item.fast_on;
                default:   blink_on = 1'b0;
            endcase
            if (ovl_show) begin
                rgb = ovl_rgb_reg;
            end else begin
                ovl_dl_next = '0;
                rgb         = blink_on ? base_rgb_next : RGB_OFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovl_dur_reg    <= 16'd80;
            boot_ms_reg    <= 16'd150;
            base_state_reg <= ST_UNKNOWN;
            base_rgb_reg   <= RGB_OFF;
            pattern_reg    <= PAT_OFF;
            ovl_rgb_reg    <= RGB_OFF;
            ovl_dl_reg     <= '0;
            boot_dl_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_OVERLAY_DURATION: ovl_dur_reg <= cfg_data;
                    CFG_BOOT_FLASH:       boot_ms_reg <= cfg_data;
                    default:              ovl_dur_reg <= ovl_dur_reg;
                endcase
            end
            if (fire) begin
                base_state_reg <= base_state_next;
                base_rgb_reg   <= base_rgb_next;
                pattern_reg    <= pattern_next;
                ovl_rgb_reg    <= ovl_rgb_next;
                ovl_dl_reg     <= ovl_dl_next;
                boot_dl_reg    <= boot_dl_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/status_led_pattern_controller.sv =====
// ----------------------------------------------------------------------------
// status_led_pattern_controller
// Status LED color and blink from state events and timestamped polls.
// Path: a poll waits in the input register; its result enters the output
// register once it is empty or read. Throughput: one item per cycle unless
// a poll waits on a stalled output; the blink phase multiplier sits before
// the input register, the state update between input and result register.
// Reset: aresetn (synchronous) restores the config registers to their defaults,
// clears base state, overlay and boot flash, and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_controller (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [slpc_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [39:0]                 s_tdata,  // state_code[3:0], now_ms[35:4], zero
    input  wire logic                        s_tuser,  // kind[0]
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata   // led_on, red_on, green_on, blue_on, zero
);
    import slpc_pkg::*;

    logic             slow_on;
    logic             fast_on;
    item_t            in_item_reg, in_item_next;
    logic             in_valid_reg, in_valid_next;
    logic [RGB_W-1:0] out_rgb_reg, out_rgb_next;
    logic             out_valid_reg, out_valid_next;
    logic [RGB_W-1:0] core_rgb;
    logic             advance;

    slpc_phase u_phase (
        .now_ms  (s_tdata[35:4]),
        .slow_on (slow_on),
        .fast_on (fast_on)
    );

    slpc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (advance),
        .item      (in_item_reg),
        .rgb       (core_rgb)
    );

    assign advance  = in_valid_reg &&
                      (in_item_reg.kind == KIND_EVENT || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_item_next  = '{kind:       kind_t'(s_tuser),
                              state_code: s_tdata[3:0],
                              now_ms:     s_tdata[35:4],
                              slow_on:    slow_on,
                              fast_on:    fast_on};
        end
        out_valid_next = out_valid_reg;
        out_rgb_next   = out_rgb_reg;
        if (advance && in_item_reg.kind == KIND_POLL) begin
            out_valid_next = 1'b1;
            out_rgb_next   = core_rgb;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_item_reg <= in_item_next;
        out_rgb_reg <= out_rgb_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_rgb_reg[0], out_rgb_reg[1], out_rgb_reg[2],
                       |out_rgb_reg};

endmodule

`default_nettype wire
